### hw/rtl/gcr_pkg.sv
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, register indexes and size tables for the glyph column
// rasterizer.
// ----------------------------------------------------------------------------
package gcr_pkg;

   // Coordinate arithmetic width; coordinates wrap modulo 2**COORD_BITS.
   localparam int COORD_BITS      = 16;
   // Upper limit on the number of bytes one glyph consumes.
   localparam int MAX_GLYPH_BYTES = 72;

   localparam int PORT_COORD_BITS = 16;
   localparam int COLOR_BITS      = 16;
   localparam int BYTE_BITS       = 8;
   localparam int ROW_BITS        = 5;
   localparam int TAKEN_BITS      = 7;
   localparam int COUNT_BITS      = 8;
   localparam int BIT_IDX_BITS    = 3;
   localparam int CSR_IDX_BITS    = 2;
   localparam int CSR_DATA_BITS   = 16;

   // Glyph byte counts, capped at the byte limit.
   localparam int RAW_BYTES_12 = ((12 + 7) / 8) * 12;
   localparam int RAW_BYTES_16 = ((16 + 7) / 8) * 16;
   localparam int RAW_BYTES_24 = ((24 + 7) / 8) * 24;
   localparam int BYTES_12 = (RAW_BYTES_12 > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : RAW_BYTES_12;
   localparam int BYTES_16 = (RAW_BYTES_16 > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : RAW_BYTES_16;
   localparam int BYTES_24 = (RAW_BYTES_24 > MAX_GLYPH_BYTES) ? MAX_GLYPH_BYTES : RAW_BYTES_24;

   // Glyph size codes.
   localparam logic [1:0] SIZE_12 = 2'd0;
   localparam logic [1:0] SIZE_16 = 2'd1;
   localparam logic [1:0] SIZE_24 = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SIZE_SELECT  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_OVERLAY_MODE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FORE_COLOR   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BACK_COLOR   = 2'd3;

   // Configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0]            size_select;
      logic                  overlay_mode;
      logic [COLOR_BITS-1:0] fore_color;
      logic [COLOR_BITS-1:0] bg_color;
   } cfg_type;

   // One pixel write.
   typedef struct packed {
      logic [PORT_COORD_BITS-1:0] x;
      logic [PORT_COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]      color;
      logic                       last;
   } pix_type;

   // Serializer sequencing.
   typedef enum logic {
      ST_IDLE,
      ST_SHIFT
   } state_type;

   // Glyph height in pixels; zero for the unsupported code.
   function automatic logic [ROW_BITS-1:0] glyph_pixels(input logic [1:0] size_select);
      logic [ROW_BITS-1:0] px;
      unique case (size_select)
         SIZE_12: px = ROW_BITS'(12);
         SIZE_16: px = ROW_BITS'(16);
         SIZE_24: px = ROW_BITS'(24);
         default: px = '0;
      endcase
      return px;
   endfunction

   // Number of bytes in a glyph of the given size.
   function automatic logic [COUNT_BITS-1:0] glyph_bytes(input logic [1:0] size_select);
      logic [COUNT_BITS-1:0] n;
      unique case (size_select)
         SIZE_12: n = COUNT_BITS'(BYTES_12);
         SIZE_16: n = COUNT_BITS'(BYTES_16);
         SIZE_24: n = COUNT_BITS'(BYTES_24);
         default: n = '0;
      endcase
      return n;
   endfunction

endpackage

### hw/rtl/gcr_csr.sv
// ----------------------------------------------------------------------------
// gcr_csr
// Configuration registers: glyph size, overlay mode and the two colors.
// ----------------------------------------------------------------------------
module gcr_csr
   import gcr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SIZE_SELECT:  cfg_in.size_select  = csr_wdata[1:0];
            CSR_OVERLAY_MODE: cfg_in.overlay_mode = csr_wdata[0];
            CSR_FORE_COLOR:   cfg_in.fore_color   = csr_wdata[COLOR_BITS-1:0];
            CSR_BACK_COLOR:   cfg_in.bg_color     = csr_wdata[COLOR_BITS-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   // Registers with their reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_select  <= SIZE_16;
         cfg_ff.overlay_mode <= 1'b0;
         cfg_ff.fore_color   <= '0;
         cfg_ff.bg_color     <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/gcr_engine.sv
// ----------------------------------------------------------------------------
// gcr_engine
// Glyph bookkeeping and bit-serial shifter: takes one bitmap byte, then
// walks its bits one per cycle unless stalled, at most one pixel write each.
// ----------------------------------------------------------------------------
module gcr_engine
   import gcr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_glyph_start,
   input  logic [PORT_COORD_BITS-1:0] req_origin_x,
   input  logic [PORT_COORD_BITS-1:0] req_origin_y,
   input  logic [BYTE_BITS-1:0]       req_glyph_byte,
   output logic                       pix_valid,
   input  logic                       pix_ready,
   output pix_type                    pix
);

   state_type state_ff, state_in;

   logic [COORD_BITS-1:0]   column_x_ff, column_x_in;
   logic [COORD_BITS-1:0]   top_y_ff, top_y_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic [TAKEN_BITS-1:0]   taken_ff, taken_in;
   logic                    active_ff, active_in;
   logic [BYTE_BITS-1:0]    bits_ff, bits_in;
   logic [BYTE_BITS-1:0]    emit_ff, emit_in;
   logic [BIT_IDX_BITS-1:0] left_ff, left_in;

   logic                    accept;
   logic                    launch;
   logic                    step;
   logic [ROW_BITS-1:0]     px;
   logic [COUNT_BITS-1:0]   count;
   logic [COORD_BITS-1:0]   col_eff;
   logic [COORD_BITS-1:0]   top_eff;
   logic [ROW_BITS-1:0]     row_eff;
   logic [TAKEN_BITS-1:0]   taken_eff;
   logic [TAKEN_BITS-1:0]   taken_inc;
   logic                    active_eff;
   logic [ROW_BITS-1:0]     rows_after;
   logic [BIT_IDX_BITS-1:0] launch_left;
   logic [BYTE_BITS-1:0]    proc_mask;
   logic [ROW_BITS-1:0]     row_next;
   logic                    col_wrap;

   assign px    = glyph_pixels(cfg.size_select);
   assign count = glyph_bytes(cfg.size_select);

   // Next state of the shifter.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (launch) state_in = ST_SHIFT;
         ST_SHIFT: if (step && (left_ff == '0)) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs of the shifter.
   always_comb begin
      req_ready = 1'b0;
      pix_valid = 1'b0;
      step      = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_ready = 1'b1;
         ST_SHIFT: begin
            pix_valid = emit_ff[BYTE_BITS-1];
            step      = !emit_ff[BYTE_BITS-1] || pix_ready;
         end
         default:  req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   // Glyph state as seen by the byte being accepted.
   always_comb begin
      if (req_glyph_start) begin
         col_eff    = req_origin_x[COORD_BITS-1:0];
         top_eff    = req_origin_y[COORD_BITS-1:0];
         row_eff    = '0;
         taken_eff  = '0;
         active_eff = 1'b1;
      end else begin
         col_eff    = column_x_ff;
         top_eff    = top_y_ff;
         row_eff    = row_ff;
         taken_eff  = taken_ff;
         active_eff = active_ff;
      end
      taken_inc = taken_eff + TAKEN_BITS'(1);
      launch    = accept && (px != '0) && active_eff
                  && ({1'b0, taken_eff} < count);
   end

   // Number of bits the byte covers before its column ends, less one.
   always_comb begin
      rows_after = px - row_eff - ROW_BITS'(1);
      if (row_eff >= px) begin
         launch_left = '0;
      end else if (rows_after > ROW_BITS'(BYTE_BITS - 1)) begin
         launch_left = BIT_IDX_BITS'(BYTE_BITS - 1);
      end else begin
         launch_left = rows_after[BIT_IDX_BITS-1:0];
      end
      proc_mask = {BYTE_BITS{1'b1}} << (BIT_IDX_BITS'(BYTE_BITS - 1) - launch_left);
   end

   // Row and column advance for one shifted bit.
   assign row_next = row_ff + ROW_BITS'(1);
   assign col_wrap = (row_next >= px);

   // Datapath next values.
   always_comb begin
      column_x_in = column_x_ff;
      top_y_in    = top_y_ff;
      row_in      = row_ff;
      taken_in    = taken_ff;
      active_in   = active_ff;
      bits_in     = bits_ff;
      emit_in     = emit_ff;
      left_in     = left_ff;
      if (accept) begin
         if (px == '0) begin
            // Unsupported size: a start only closes the open glyph.
            if (req_glyph_start) active_in = 1'b0;
         end else begin
            column_x_in = col_eff;
            top_y_in    = top_eff;
            row_in      = row_eff;
            taken_in    = taken_eff;
            active_in   = active_eff;
            if (active_eff) begin
               if (launch) begin
                  taken_in  = taken_inc;
                  active_in = ({1'b0, taken_inc} < count);
                  bits_in   = req_glyph_byte;
                  emit_in   = proc_mask & (req_glyph_byte | {BYTE_BITS{!cfg.overlay_mode}});
                  left_in   = launch_left;
               end else begin
                  // Byte count already met: close the glyph.
                  active_in = 1'b0;
               end
            end
         end
      end else if (step) begin
         bits_in = bits_ff << 1;
         emit_in = emit_ff << 1;
         left_in = left_ff - BIT_IDX_BITS'(1);
         if (col_wrap) begin
            row_in      = '0;
            column_x_in = column_x_ff + COORD_BITS'(1);
         end else begin
            row_in = row_next;
         end
      end
   end

   // Pixel write for the bit at the head of the shifter.
   always_comb begin
      pix.x     = PORT_COORD_BITS'(column_x_ff);
      pix.y     = PORT_COORD_BITS'(COORD_BITS'(top_y_ff + COORD_BITS'(row_ff)));
      pix.color = bits_ff[BYTE_BITS-1] ? cfg.fore_color : cfg.bg_color;
      pix.last  = (emit_ff[BYTE_BITS-2:0] == '0);
   end

   // Control and glyph state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         column_x_ff <= '0;
         top_y_ff    <= '0;
         row_ff      <= '0;
         taken_ff    <= '0;
         active_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         column_x_ff <= column_x_in;
         top_y_ff    <= top_y_in;
         row_ff      <= row_in;
         taken_ff    <= taken_in;
         active_ff   <= active_in;
      end
   end

   // Shift registers for the byte in flight.
   always_ff @(posedge clock) begin
      bits_ff <= bits_in;
      emit_ff <= emit_in;
      left_ff <= left_in;
   end

endmodule

### hw/rtl/glyph_column_rasterizer.sv
// ----------------------------------------------------------------------------
// glyph_column_rasterizer
// Turns the column-major bitmap bytes of a 12, 16 or 24 pixel glyph into a
// stream of pixel writes.
// ----------------------------------------------------------------------------
// Each accepted byte is taken in, then walked over the bits it covers:
// eight, or fewer when the glyph column ends inside the byte. An ignored
// byte (no glyph open, byte count met, unsupported size) is only taken in.
// No new byte is taken until the last is walked. The shifter walks one bit
// per cycle unless the output stalls, handing at most one pixel write per
// cycle to the output register; a stall holds it on the next bit to write.
// In overlay mode a clear bit is still walked but makes no write; run_last
// marks each byte's final write. The user must write configuration only
// while no byte is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module glyph_column_rasterizer
   import gcr_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_glyph_start,
   input  logic [PORT_COORD_BITS-1:0] req_origin_x,
   input  logic [PORT_COORD_BITS-1:0] req_origin_y,
   input  logic [BYTE_BITS-1:0]       req_glyph_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_x,
   output logic [PORT_COORD_BITS-1:0] rsp_pixel_y,
   output logic [COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                       rsp_run_last
);

   cfg_type cfg;
   pix_type pix;
   logic    pix_valid;
   logic    pix_ready;
   logic    rsp_valid_ff, rsp_valid_in;
   pix_type rsp_ff, rsp_in;

   gcr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gcr_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_glyph_start (req_glyph_start),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_glyph_byte  (req_glyph_byte),
      .pix_valid       (pix_valid),
      .pix_ready       (pix_ready),
      .pix             (pix)
   );

   // Output register: takes a new item whenever it is empty or being drained.
   assign pix_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (pix_valid && pix_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = pix;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_ff.x;
   assign rsp_pixel_y     = rsp_ff.y;
   assign rsp_pixel_color = rsp_ff.color;
   assign rsp_run_last    = rsp_ff.last;

endmodule
